// ===== hw/rtl/hrlp_pkg.sv =====
// shared types, codes and character tables for the http request line parser
// no dependencies; imported by every module of the block
package hrlp_pkg;

    // request queue geometry
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // result kinds
    localparam logic [1:0] KIND_URI     = 2'd0;
    localparam logic [1:0] KIND_QUERY   = 2'd1;
    localparam logic [1:0] KIND_SUMMARY = 2'd2;

    // method codes
    localparam logic [2:0] METH_GET     = 3'd0;
    localparam logic [2:0] METH_HEAD    = 3'd1;
    localparam logic [2:0] METH_POST    = 3'd2;
    localparam logic [2:0] METH_PUT     = 3'd3;
    localparam logic [2:0] METH_UNKNOWN = 3'd4;

    // status codes
    localparam logic [1:0] STAT_OK     = 2'd0;
    localparam logic [1:0] STAT_NO_REQ = 2'd1;
    localparam logic [1:0] STAT_BAD    = 2'd2;

    // characters
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_QUEST = 8'h3F;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LF    = 8'h66;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UF    = 8'h46;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;

    localparam logic [2:0] PROTO_LEN = 3'd5;
    localparam logic [7:0] SAT_MAX   = 8'd255;

    // input request
    typedef struct packed {
        logic       cmd;
        logic [7:0] data;
    } t_in_req;

    // result item
    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] out_byte;
        logic [2:0] method;
        logic [7:0] version_major;
        logic [7:0] version_minor;
        logic       keep_alive;
        logic [1:0] status;
    } t_out_rsp;

    // classified request as it sits in the queue
    typedef struct packed {
        logic       cmd;
        logic [7:0] data;
        logic       is_zero;
        logic       is_space;
        logic       is_plus;
        logic       is_pct;
        logic       is_quest;
        logic       is_dot;
        logic       is_digit;
        logic       hex_ok;
        logic       hex_sign;
        logic [3:0] hex_val;
    } t_cls;

    // letters of the known verbs
    function automatic logic [7:0] verb_char(input logic [1:0] k, input logic [1:0] idx);
        logic [7:0] ch;
        case ({k, idx})
            4'b00_00: ch = 8'h47; // G
            4'b00_01: ch = 8'h45; // E
            4'b00_10: ch = 8'h54; // T
            4'b01_00: ch = 8'h48; // H
            4'b01_01: ch = 8'h45; // E
            4'b01_10: ch = 8'h41; // A
            4'b01_11: ch = 8'h44; // D
            4'b10_00: ch = 8'h50; // P
            4'b10_01: ch = 8'h4F; // O
            4'b10_10: ch = 8'h53; // S
            4'b10_11: ch = 8'h54; // T
            4'b11_00: ch = 8'h50; // P
            4'b11_01: ch = 8'h55; // U
            4'b11_10: ch = 8'h54; // T
            default:  ch = 8'h00;
        endcase
        return ch;
    endfunction

    // verb lengths
    function automatic logic [2:0] verb_len(input logic [1:0] k);
        logic [2:0] n;
        case (k)
            2'd1, 2'd2: n = 3'd4;
            default:    n = 3'd3;
        endcase
        return n;
    endfunction

    // protocol prefix text
    function automatic logic [7:0] proto_char(input logic [2:0] idx);
        logic [7:0] ch;
        case (idx)
            3'd0:    ch = 8'h48; // H
            3'd1:    ch = 8'h54; // T
            3'd2:    ch = 8'h54; // T
            3'd3:    ch = 8'h50; // P
            3'd4:    ch = 8'h2F; // slash
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

// ===== hw/rtl/hrlp_front.sv =====
// front end: request handshake and byte classification
// depends on hrlp_pkg; feeds hrlp_queue
module hrlp_front
    import hrlp_pkg::*;
(
    input  logic    i_valid,
    input  t_in_req i_req,
    input  logic    i_full,
    output logic    o_stall,
    output logic    o_push,
    output t_cls    o_cls
);

    logic [7:0] c;

    // accept whenever the queue has room
    assign o_stall = i_full;
    assign o_push  = i_valid && !i_full;
    assign c       = i_req.data;

    // character classes used by the parser
    always_comb begin
        o_cls          = '0;
        o_cls.cmd      = i_req.cmd;
        o_cls.data     = c;
        o_cls.is_zero  = (c == CH_NUL);
        o_cls.is_space = (c == CH_SPACE);
        o_cls.is_plus  = (c == CH_PLUS);
        o_cls.is_pct   = (c == CH_PCT);
        o_cls.is_quest = (c == CH_QUEST);
        o_cls.is_dot   = (c == CH_DOT);
        o_cls.is_digit = c inside {[CH_ZERO:CH_NINE]};
        o_cls.hex_sign = (c inside {CH_SPACE, CH_PLUS, [CH_TAB:CH_CR]});
        if (c inside {[CH_ZERO:CH_NINE]}) begin
            o_cls.hex_ok  = 1'b1;
            o_cls.hex_val = 4'(c - CH_ZERO);
        end else if (c inside {[CH_LA:CH_LF]}) begin
            o_cls.hex_ok  = 1'b1;
            o_cls.hex_val = 4'(c - CH_LA + 8'd10);
        end else if (c inside {[CH_UA:CH_UF]}) begin
            o_cls.hex_ok  = 1'b1;
            o_cls.hex_val = 4'(c - CH_UA + 8'd10);
        end
    end

endmodule

// ===== hw/rtl/hrlp_queue.sv =====
// short request queue between the front end and the parser core
// depends on hrlp_pkg for the entry type and depth
module hrlp_queue
    import hrlp_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cls i_cls,
    input  logic i_pop,
    output logic o_full,
    output logic o_empty,
    output t_cls o_cls
);

    t_cls                r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr_ptr, r_rd_ptr;
    logic [QUEUE_AW:0]   r_count;

    assign o_full  = (r_count == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_cls   = r_mem[r_rd_ptr];

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cls;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== hw/rtl/hrlp_back.sv =====
// parser core: request line state machine and registered result stage
// depends on hrlp_pkg; drains hrlp_queue
module hrlp_back
    import hrlp_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_empty,
    input  t_cls     i_cls,
    output logic     o_pop,
    input  logic     i_stall,
    output logic     o_valid,
    output t_out_rsp o_rsp
);

    // parser phases
    localparam logic [3:0] PH_METHOD = 4'd0;
    localparam logic [3:0] PH_SKIP1  = 4'd1;
    localparam logic [3:0] PH_URI    = 4'd2;
    localparam logic [3:0] PH_HEX1   = 4'd3;
    localparam logic [3:0] PH_HEX2   = 4'd4;
    localparam logic [3:0] PH_QUERY  = 4'd5;
    localparam logic [3:0] PH_SKIP2  = 4'd6;
    localparam logic [3:0] PH_PROTO  = 4'd7;
    localparam logic [3:0] PH_MAJOR  = 4'd8;
    localparam logic [3:0] PH_MINOR  = 4'd9;
    localparam logic [3:0] PH_TAIL   = 4'd10;
    localparam logic [3:0] PH_BAD    = 4'd11;
    localparam logic [3:0] PH_ENDED  = 4'd12;

    typedef struct packed {
        logic [1:0] err;
        logic [7:0] major;
        logic [7:0] minor;
    } t_fin;

    // decimal digit append with saturation
    function automatic logic [7:0] sat_dec(input logic [7:0] v, input logic [3:0] d);
        logic [11:0] n;
        n = {v, 3'b000} + {3'b000, v, 1'b0} + {8'b0, d};
        return (n > 12'(SAT_MAX)) ? SAT_MAX : n[7:0];
    endfunction

    // outcome when the line ends in a given phase
    function automatic t_fin finish(input logic [3:0] ph, input logic [1:0] ds,
                                    input logic [7:0] maj, input logic [7:0] mnr);
        t_fin f;
        f.major = maj;
        f.minor = mnr;
        case (ph)
            PH_METHOD, PH_SKIP1: f.err = STAT_NO_REQ;
            PH_URI, PH_HEX1, PH_HEX2, PH_QUERY: begin
                f.err   = STAT_OK;
                f.major = 8'd0;
                f.minor = 8'd9;
            end
            PH_MINOR: f.err = ds[1] ? STAT_OK : STAT_BAD;
            PH_TAIL:  f.err = STAT_OK;
            default:  f.err = STAT_BAD;
        endcase
        if (f.err != STAT_OK) begin
            f.major = 8'd0;
            f.minor = 8'd0;
        end
        return f;
    endfunction

    logic [3:0] r_phase, n_phase;
    logic [2:0] r_verb_length, n_verb_length;
    logic [3:0] r_verb_cand, n_verb_cand;
    logic [2:0] r_method, n_method;
    logic       r_hex_ok, n_hex_ok;
    logic       r_hex_sign, n_hex_sign;
    logic [3:0] r_hex_val, n_hex_val;
    logic [2:0] r_proto_index, n_proto_index;
    logic [7:0] r_major, n_major;
    logic [7:0] r_minor, n_minor;
    logic [1:0] r_digit_seen, n_digit_seen;
    logic [1:0] r_err, n_err;
    logic       r_out_valid, n_out_valid;
    t_out_rsp   r_out, n_out;

    logic       take;
    logic       res_v;
    t_out_rsp   res;
    logic [3:0] cur;
    logic [2:0] pidx;
    t_fin       fin;
    logic [7:0] hex_v;

    // pop one request whenever the result register can take its outcome
    assign take    = !i_empty && (!r_out_valid || !i_stall);
    assign o_pop   = take;
    assign o_valid = r_out_valid;
    assign o_rsp   = r_out;

    // percent escape value from the held first byte and this byte
    always_comb begin
        if (r_hex_sign) begin
            hex_v = i_cls.hex_ok ? {4'b0, i_cls.hex_val} : 8'd0;
        end else if (r_hex_ok) begin
            hex_v = i_cls.hex_ok ? {r_hex_val, i_cls.hex_val} : {4'b0, r_hex_val};
        end else begin
            hex_v = 8'd0;
        end
    end

    // line outcome, from stored values once the line has ended early
    always_comb begin
        if (r_phase == PH_ENDED) begin
            fin.err   = r_err;
            fin.major = r_major;
            fin.minor = r_minor;
        end else begin
            fin = finish(r_phase, r_digit_seen, r_major, r_minor);
        end
    end

    // parser state machine
    always_comb begin
        n_phase       = r_phase;
        n_verb_length = r_verb_length;
        n_verb_cand   = r_verb_cand;
        n_method      = r_method;
        n_hex_ok      = r_hex_ok;
        n_hex_sign    = r_hex_sign;
        n_hex_val     = r_hex_val;
        n_proto_index = r_proto_index;
        n_major       = r_major;
        n_minor       = r_minor;
        n_digit_seen  = r_digit_seen;
        n_err         = r_err;
        res_v         = 1'b0;
        res           = '0;
        cur           = r_phase;
        pidx          = r_proto_index;

        // leaving a space run falls through into the next phase
        if (r_phase == PH_SKIP1 && !i_cls.is_space) begin
            cur = PH_URI;
        end
        if (r_phase == PH_SKIP2 && !i_cls.is_space) begin
            cur  = PH_PROTO;
            pidx = 3'd0;
        end

        if (take) begin
            if (i_cls.cmd) begin
                // end of line: summary and back to reset values
                res_v             = 1'b1;
                res.kind          = KIND_SUMMARY;
                res.method        = r_method;
                res.version_major = fin.major;
                res.version_minor = fin.minor;
                res.status        = fin.err;
                res.keep_alive    = (fin.err == STAT_OK) &&
                                    ((fin.major > 8'd1) ||
                                     (fin.major == 8'd1 && fin.minor >= 8'd1));
                n_phase       = PH_METHOD;
                n_verb_length = 3'd0;
                n_verb_cand   = 4'hF;
                n_method      = METH_UNKNOWN;
                n_hex_ok      = 1'b0;
                n_hex_sign    = 1'b0;
                n_hex_val     = 4'd0;
                n_proto_index = 3'd0;
                n_major       = 8'd0;
                n_minor       = 8'd0;
                n_digit_seen  = 2'd0;
                n_err         = STAT_OK;
            end else if (r_phase == PH_ENDED) begin
                n_phase = PH_ENDED;
            end else if (i_cls.is_zero) begin
                // zero byte ends the line early
                n_err   = fin.err;
                n_major = fin.major;
                n_minor = fin.minor;
                n_phase = PH_ENDED;
            end else begin
                case (cur)
                    PH_METHOD: begin
                        if (i_cls.is_space) begin
                            n_method = METH_UNKNOWN;
                            for (int k = 0; k < 4; k++) begin
                                if (r_verb_cand[k] && verb_len(2'(k)) == r_verb_length) begin
                                    n_method = 3'(k);
                                end
                            end
                            n_phase = PH_SKIP1;
                        end else begin
                            for (int k = 0; k < 4; k++) begin
                                if (r_verb_length >= verb_len(2'(k)) ||
                                    verb_char(2'(k), r_verb_length[1:0]) != i_cls.data) begin
                                    n_verb_cand[k] = 1'b0;
                                end
                            end
                            if (r_verb_length < 3'd7) begin
                                n_verb_length = r_verb_length + 3'd1;
                            end
                        end
                    end
                    PH_SKIP1: begin
                        n_phase = PH_SKIP1;
                    end
                    PH_URI: begin
                        if (i_cls.is_space) begin
                            n_phase = PH_SKIP2;
                        end else if (i_cls.is_quest) begin
                            n_phase = PH_QUERY;
                        end else if (i_cls.is_pct) begin
                            n_phase = PH_HEX1;
                        end else begin
                            n_phase      = PH_URI;
                            res_v        = 1'b1;
                            res.kind     = KIND_URI;
                            res.out_byte = i_cls.is_plus ? CH_SPACE : i_cls.data;
                        end
                    end
                    PH_HEX1: begin
                        n_hex_ok   = i_cls.hex_ok;
                        n_hex_sign = i_cls.hex_sign;
                        n_hex_val  = i_cls.hex_val;
                        n_phase    = PH_HEX2;
                    end
                    PH_HEX2: begin
                        n_phase = PH_URI;
                        if (hex_v != 8'd0) begin
                            res_v        = 1'b1;
                            res.kind     = KIND_URI;
                            res.out_byte = hex_v;
                        end
                    end
                    PH_QUERY: begin
                        if (i_cls.is_space) begin
                            n_phase = PH_SKIP2;
                        end else begin
                            res_v        = 1'b1;
                            res.kind     = KIND_QUERY;
                            res.out_byte = i_cls.data;
                        end
                    end
                    PH_SKIP2: begin
                        n_phase = PH_SKIP2;
                    end
                    PH_PROTO: begin
                        if (pidx < PROTO_LEN && proto_char(pidx) == i_cls.data) begin
                            n_proto_index = pidx + 3'd1;
                            n_phase = (pidx + 3'd1 == PROTO_LEN) ? PH_MAJOR : PH_PROTO;
                        end else begin
                            n_proto_index = pidx;
                            n_phase       = PH_BAD;
                        end
                    end
                    PH_MAJOR: begin
                        if (i_cls.is_digit) begin
                            n_major         = sat_dec(r_major, i_cls.hex_val);
                            n_digit_seen[0] = 1'b1;
                        end else if (i_cls.is_dot && r_digit_seen[0]) begin
                            n_phase = PH_MINOR;
                        end else begin
                            n_phase = PH_BAD;
                        end
                    end
                    PH_MINOR: begin
                        if (i_cls.is_digit) begin
                            n_minor         = sat_dec(r_minor, i_cls.hex_val);
                            n_digit_seen[1] = 1'b1;
                        end else begin
                            n_phase = r_digit_seen[1] ? PH_TAIL : PH_BAD;
                        end
                    end
                    default: begin
                        n_phase = r_phase;
                    end
                endcase
            end
        end
    end

    // result register: load a new result or drain the taken one
    always_comb begin
        n_out_valid = r_out_valid;
        n_out       = r_out;
        if (take && res_v) begin
            n_out_valid = 1'b1;
            n_out       = res;
        end else if (!i_stall) begin
            n_out_valid = 1'b0;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_METHOD;
            r_verb_length <= 3'd0;
            r_verb_cand   <= 4'hF;
            r_method      <= METH_UNKNOWN;
            r_hex_ok      <= 1'b0;
            r_hex_sign    <= 1'b0;
            r_hex_val     <= 4'd0;
            r_proto_index <= 3'd0;
            r_major       <= 8'd0;
            r_minor       <= 8'd0;
            r_digit_seen  <= 2'd0;
            r_err         <= STAT_OK;
            r_out_valid   <= 1'b0;
        end else begin
            r_phase       <= n_phase;
            r_verb_length <= n_verb_length;
            r_verb_cand   <= n_verb_cand;
            r_method      <= n_method;
            r_hex_ok      <= n_hex_ok;
            r_hex_sign    <= n_hex_sign;
            r_hex_val     <= n_hex_val;
            r_proto_index <= n_proto_index;
            r_major       <= n_major;
            r_minor       <= n_minor;
            r_digit_seen  <= n_digit_seen;
            r_err         <= n_err;
            r_out_valid   <= n_out_valid;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

endmodule

// ===== hw/rtl/http_request_line_parser.sv =====
// http request line parser: one byte or end-of-line request per cycle unless stalled.
// an accepted request is written into the queue, and the result register is loaded
// with its result, if any, when the parser pops it from the queue.
// throughput: one request per cycle unless stalled, set by the single parser step per byte.
// the four-entry queue keeps accepting until full while a result waits on i_out_stall.
// reset (i_rst_n low, synchronous) empties the queue and result stage and
// returns the parser to the start of a line.
module http_request_line_parser
    import hrlp_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  t_in_req  i_in_req,
    output logic     o_out_valid,
    input  logic     i_out_stall,
    output t_out_rsp o_out_rsp
);

    logic push, pop, full, empty;
    t_cls cls_in, cls_out;

    // request handshake and classification
    hrlp_front u_front (
        .i_valid (i_in_valid),
        .i_req   (i_in_req),
        .i_full  (full),
        .o_stall (o_in_stall),
        .o_push  (push),
        .o_cls   (cls_in)
    );

    // decoupling queue
    hrlp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cls   (cls_in),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_cls   (cls_out)
    );

    // parser core and result stage
    hrlp_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .i_cls   (cls_out),
        .o_pop   (pop),
        .i_stall (i_out_stall),
        .o_valid (o_out_valid),
        .o_rsp   (o_out_rsp)
    );

endmodule

// ===== bench/http_request_line_parser_tb.sv =====
// testbench for http_request_line_parser: random and directed request lines
// against a built-in line tracker; depends on hrlp_pkg and the parser rtl
module http_request_line_parser_tb;
    import hrlp_pkg::*;

    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam int         ITEM_TARGET = 950;
    localparam int         SQUEEZE_CYCLES = 300;

    // parser phases as the tracker sees them
    typedef enum logic [3:0] {
        LP_METHOD, LP_SKIP1, LP_URI, LP_HEX1, LP_HEX2, LP_QUERY, LP_SKIP2,
        LP_PROTO, LP_MAJOR, LP_MINOR, LP_TAIL, LP_BAD, LP_ENDED
    } t_parse_phase;

    // tracks one request line and holds the results it still owes
    class line_tracker;
        t_out_rsp     pending[$];
        int           fault_count;
        t_parse_phase line_phase;
        logic [2:0]   word_len;
        logic [3:0]   verb_mask;
        logic [2:0]   meth;
        logic         saw_space;
        logic [7:0]   hex_hi;
        logic [2:0]   proto_pos;
        logic [7:0]   major;
        logic [7:0]   minor;
        logic [1:0]   digits_seen;
        logic [1:0]   err;
        string        verbs[4];
        string        proto_text;

        function new();
            verbs = '{"GET", "HEAD", "POST", "PUT"};
            proto_text = "HTTP/";
            fault_count = 0;
            clear_line();
        endfunction

        function void clear_line();
            line_phase = LP_METHOD;
            word_len = '0;
            verb_mask = 4'hF;
            meth = METH_UNKNOWN;
            saw_space = 1'b0;
            hex_hi = '0;
            proto_pos = '0;
            major = '0;
            minor = '0;
            digits_seen = '0;
            err = STAT_OK;
        endfunction

        function bit is_blank(logic [7:0] c);
            return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
        endfunction

        function bit is_digit(logic [7:0] c);
            return c >= CH_ZERO && c <= CH_NINE;
        endfunction

        function int hex_value(logic [7:0] c);
            if (is_digit(c)) return int'(c - CH_ZERO);
            if (c >= CH_LA && c <= CH_LF) return int'(c - CH_LA) + 10;
            if (c >= CH_UA && c <= CH_UF) return int'(c - CH_UA) + 10;
            return -1;
        endfunction

        // two escape bytes read the way a base-16 strtol would
        function int decode_escape(logic [7:0] a, logic [7:0] b);
            int ha;
            int hb;
            ha = hex_value(a);
            hb = hex_value(b);
            if (is_blank(a) || a == CH_PLUS) return (hb >= 0) ? hb : 0;
            if (a == CH_MINUS) return 0;
            if (ha >= 0) return (hb >= 0) ? ha * 16 + hb : ha;
            return 0;
        endfunction

        function logic [7:0] grow_digit(logic [7:0] v, logic [7:0] c);
            int n;
            n = int'(v) * 10 + int'(c - CH_ZERO);
            return (n > 255) ? SAT_MAX : n[7:0];
        endfunction

        // fix the outcome of the line at its end or at a zero byte
        function void close_line();
            if (line_phase == LP_ENDED) return;
            case (line_phase)
                LP_METHOD, LP_SKIP1: begin
                    err = STAT_NO_REQ;
                end
                LP_URI, LP_HEX1, LP_HEX2, LP_QUERY: begin
                    // no version given means http 0.9
                    err = STAT_OK;
                    major = '0;
                    minor = 8'd9;
                end
                LP_MINOR: err = digits_seen[1] ? STAT_OK : STAT_BAD;
                LP_TAIL:  err = STAT_OK;
                default:  err = STAT_BAD;
            endcase
            if (err != STAT_OK) begin
                major = '0;
                minor = '0;
            end
            line_phase = LP_ENDED;
        endfunction

        function void emit_byte(logic [1:0] kind, logic [7:0] b);
            t_out_rsp rsp;
            rsp = '0;
            rsp.kind = kind;
            rsp.out_byte = b;
            pending.insert(pending.size(), rsp);
        endfunction

        // note an accepted request and queue what it should produce
        function void take_request(t_in_req req);
            t_out_rsp   rsp;
            logic [7:0] c;
            int         v;
            int         k;
            c = req.data;
            if (req.cmd) begin
                close_line();
                rsp = '0;
                rsp.kind = KIND_SUMMARY;
                rsp.method = meth;
                rsp.version_major = major;
                rsp.version_minor = minor;
                rsp.keep_alive = (err == STAT_OK) &&
                                 (major > 8'd1 || (major == 8'd1 && minor >= 8'd1));
                rsp.status = err;
                pending.insert(pending.size(), rsp);
                clear_line();
                return;
            end
            if (line_phase == LP_ENDED) return;
            if (c == CH_NUL) begin
                close_line();
                return;
            end
            // leaving the space runs falls into the next field
            if (line_phase == LP_SKIP1) begin
                if (c == CH_SPACE) return;
                line_phase = LP_URI;
            end
            if (line_phase == LP_SKIP2) begin
                if (c == CH_SPACE) return;
                line_phase = LP_PROTO;
                proto_pos = '0;
            end
            case (line_phase)
                LP_METHOD: begin
                    if (c == CH_SPACE) begin
                        meth = METH_UNKNOWN;
                        for (k = 0; k < 4; k++)
                            if (verb_mask[k] && verbs[k].len() == int'(word_len))
                                meth = 3'(k);
                        saw_space = 1'b1;
                        line_phase = LP_SKIP1;
                    end else begin
                        for (k = 0; k < 4; k++)
                            if (int'(word_len) >= verbs[k].len() || verbs[k][word_len] != c)
                                verb_mask[k] = 1'b0;
                        if (word_len < 3'd7) word_len++;
                    end
                end
                LP_URI: begin
                    if (c == CH_SPACE) line_phase = LP_SKIP2;
                    else if (c == CH_QUEST) line_phase = LP_QUERY;
                    else if (c == CH_PCT) line_phase = LP_HEX1;
                    else emit_byte(KIND_URI, (c == CH_PLUS) ? CH_SPACE : c);
                end
                LP_HEX1: begin
                    hex_hi = c;
                    line_phase = LP_HEX2;
                end
                LP_HEX2: begin
                    v = decode_escape(hex_hi, c);
                    line_phase = LP_URI;
                    if (v >= 1 && v <= 255) emit_byte(KIND_URI, v[7:0]);
                end
                LP_QUERY: begin
                    if (c == CH_SPACE) line_phase = LP_SKIP2;
                    else emit_byte(KIND_QUERY, c);
                end
                LP_PROTO: begin
                    if (proto_pos < PROTO_LEN && proto_text[proto_pos] == c) begin
                        proto_pos++;
                        if (proto_pos == PROTO_LEN) line_phase = LP_MAJOR;
                    end else begin
                        line_phase = LP_BAD;
                    end
                end
                LP_MAJOR: begin
                    if (is_digit(c)) begin
                        major = grow_digit(major, c);
                        digits_seen[0] = 1'b1;
                    end else if (c == CH_DOT && digits_seen[0]) begin
                        line_phase = LP_MINOR;
                    end else begin
                        line_phase = LP_BAD;
                    end
                end
                LP_MINOR: begin
                    if (is_digit(c)) begin
                        minor = grow_digit(minor, c);
                        digits_seen[1] = 1'b1;
                    end else begin
                        line_phase = digits_seen[1] ? LP_TAIL : LP_BAD;
                    end
                end
                default: ;
            endcase
        endfunction

        function void compare_field(string name, logic [7:0] want, logic [7:0] got);
            if (got !== want) begin
                $error("%s: expected %0d, actual %0d", name, want, got);
                fault_count++;
            end
        endfunction

        // compare one result with the oldest one owed
        function void check_result(t_out_rsp got);
            t_out_rsp want;
            if (pending.size() == 0) begin
                $error("result with none owed: kind %0d byte %0d", got.kind, got.out_byte);
                fault_count++;
                return;
            end
            want = pending.pop_front();
            compare_field("kind", want.kind, got.kind);
            compare_field("out_byte", want.out_byte, got.out_byte);
            compare_field("method", want.method, got.method);
            compare_field("version_major", want.version_major, got.version_major);
            compare_field("version_minor", want.version_minor, got.version_minor);
            compare_field("keep_alive", want.keep_alive, got.keep_alive);
            compare_field("status", want.status, got.status);
        endfunction
    endclass

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_stall;
    t_in_req    i_in_req;
    logic       o_out_valid;
    logic       i_out_stall;
    t_out_rsp   o_out_rsp;

    line_tracker tracker = new();
    logic [7:0]  line_bytes[$];
    int          sent_items = 0;
    bit          calm = 1'b0;
    bit          squeeze_req = 1'b0;
    bit          squeeze_done = 1'b0;
    string       hex_chars = "0123456789abcdefABCDEF";

    http_request_line_parser u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_req    (i_in_req),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_rsp   (o_out_rsp)
    );

    always #5 i_clk = ~i_clk;

    // mostly short gaps, a few long ones, none in a calm stretch
    function automatic int pick_gap();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 20);
    endfunction

    // offer one request and hold it until taken
    task automatic push_request(input t_in_req req);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_req <= req;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        tracker.take_request(req);
        sent_items++;
    endtask

    // send the line bytes, then the end-of-line request
    task automatic send_line();
        t_in_req req;
        int      i;
        for (i = 0; i < line_bytes.size(); i++) begin
            req.cmd = 1'b0;
            req.data = line_bytes[i];
            push_request(req);
        end
        req.cmd = 1'b1;
        req.data = 8'($urandom);
        push_request(req);
    endtask

    // append one byte to the line under construction
    function automatic void add_byte(logic [7:0] b);
        line_bytes.insert(line_bytes.size(), b);
    endfunction

    function automatic void add_text(string s);
        int i;
        for (i = 0; i < s.len(); i++) add_byte(s[i]);
    endfunction

    function automatic void add_digits(int n);
        repeat (n) add_byte(CH_ZERO + 8'($urandom_range(0, 9)));
    endfunction

    function automatic void add_spaces(int lo, int hi);
        repeat ($urandom_range(lo, hi)) add_byte(CH_SPACE);
    endfunction

    // one byte of an escape pair, biased toward the interesting cases
    function automatic logic [7:0] escape_byte();
        case ($urandom_range(0, 5))
            0, 1:    return hex_chars[$urandom_range(0, hex_chars.len() - 1)];
            2:       return ($urandom_range(0, 1) != 0) ? CH_SPACE :
                            8'($urandom_range(CH_TAB, CH_CR));
            3:       return CH_PLUS;
            4:       return CH_MINUS;
            default: return 8'($urandom);
        endcase
    endfunction

    // version number: usually one digit, sometimes none or enough to saturate
    function automatic void add_number(bit low_bias);
        case ($urandom_range(0, 9))
            0:       ;
            1:       add_digits($urandom_range(3, 4));
            default: begin
                if ($urandom_range(0, 1) != 0)
                    add_byte(low_bias ? CH_ZERO + 8'($urandom_range(0, 1)) :
                                        CH_ZERO + 8'd1);
                else
                    add_digits(1);
            end
        endcase
    endfunction

    // build one request line: mostly well formed with random content
    function automatic void make_line();
        int n;
        line_bytes.delete();
        // pure noise
        if ($urandom_range(0, 15) == 0) begin
            repeat ($urandom_range(0, 12)) add_byte(8'($urandom));
            return;
        end
        // method word
        case ($urandom_range(0, 11))
            0, 1: add_text("GET");
            2:    add_text("HEAD");
            3:    add_text("POST");
            4:    add_text("PUT");
            5:    add_text("GETS");
            6:    add_text("PU");
            7:    add_text("HEA");
            8:    add_text("get");
            9:    ;
            default: repeat ($urandom_range(1, 9))
                add_byte(CH_UA + 8'($urandom_range(0, 25)));
        endcase
        if ($urandom_range(0, 19) == 0) return;
        add_spaces(1, 3);
        if ($urandom_range(0, 11) == 0) return;
        // uri and query
        n = $urandom_range(0, 10);
        repeat (n) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: add_byte(8'($urandom_range(33, 126)));
                4:          add_byte(CH_PLUS);
                5, 6: begin
                    add_byte(CH_PCT);
                    add_byte(escape_byte());
                    add_byte(escape_byte());
                end
                7:          add_byte(8'($urandom_range(128, 255)));
                8:          add_byte(CH_QUEST);
                default:    add_byte(8'($urandom));
            endcase
        end
        if ($urandom_range(0, 7) != 0) begin
            add_spaces(1, 2);
            // protocol and version
            case ($urandom_range(0, 9))
                0:       add_text("HTTX/");
                1:       add_text("HTT");
                2:       add_text("http/");
                default: add_text("HTTP/");
            endcase
            add_number(1'b0);
            if ($urandom_range(0, 9) == 0) add_byte(8'($urandom_range(33, 126)));
            else add_byte(CH_DOT);
            add_number(1'b1);
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 3)) add_byte(8'($urandom));
        end
        // early zero byte
        if ($urandom_range(0, 11) == 0 && line_bytes.size() > 0)
            line_bytes.insert($urandom_range(0, line_bytes.size() - 1), CH_NUL);
    endfunction

    // result side: random stalls and one long hold-off
    initial begin : result_sink
        int hold;
        hold = 0;
        i_out_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid === 1'b1 && !i_out_stall)
                tracker.check_result(o_out_rsp);
            if (hold == 0 && !calm && $urandom_range(0, 3) == 0) hold = pick_gap();
            if (squeeze_req && !squeeze_done) begin
                hold = SQUEEZE_CYCLES;
                squeeze_done = 1'b1;
            end
            i_out_stall <= (hold > 0);
            if (hold > 0) hold--;
        end
    end

    // stimulus
    initial begin : line_source
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_req = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: a full line, an empty verb with a top byte, a zero byte, empty line
        line_bytes.delete();
        add_text("GET / HTTP/1.1");
        send_line();
        line_bytes = '{CH_SPACE, 8'hFF};
        send_line();
        line_bytes = '{8'h48, CH_NUL, 8'h7A};
        send_line();
        line_bytes.delete();
        send_line();

        // random lines
        while (sent_items < ITEM_TARGET) begin
            if ($urandom_range(0, 9) == 0) calm = ~calm;
            if (!squeeze_req && sent_items >= ITEM_TARGET / 2) begin
                calm = 1'b1;
                squeeze_req = 1'b1;
            end
            make_line();
            send_line();
        end
        i_in_valid <= 1'b0;

        // drain, then allow the pipeline to settle
        while (tracker.pending.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (tracker.fault_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // run limit
    initial begin : watchdog
        #5000000;
        $display("status: fail");
        $finish;
    end

endmodule
